FILE: design/mthl_pkg.sv
// Package for the markup tag lexer core: lexer state codes, byte constants,
// the result struct and the state-to-colour function.
// No dependencies.
`default_nettype none

package mthl_pkg;

  typedef logic [3:0] lex_state_t;

  localparam lex_state_t ST_TEXT  = 4'd0;
  localparam lex_state_t ST_OPEN  = 4'd1;
  localparam lex_state_t ST_BANG  = 4'd2;
  localparam lex_state_t ST_CMT   = 4'd3;
  localparam lex_state_t ST_TAG   = 4'd4;
  localparam lex_state_t ST_SPACE = 4'd5;
  localparam lex_state_t ST_SLASH = 4'd6;
  localparam lex_state_t ST_NAME  = 4'd7;
  localparam lex_state_t ST_EQ    = 4'd8;
  localparam lex_state_t ST_VAL   = 4'd9;
  localparam lex_state_t ST_AFTER = 4'd10;
  localparam lex_state_t ST_NONE  = 4'd15;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] DASH_MAX = 2'd3;

  typedef struct packed {
    logic       colour_change;
    logic [2:0] colour_index;
    logic       lex_error;
  } lex_res_t;

  typedef struct packed {
    logic       coloured;
    logic [2:0] index;
  } colour_t;

  // Colour index is the terminal colour code less 30.
  function automatic colour_t state_colour(lex_state_t s);
    colour_t c;
    c.coloured = 1'b1;
    c.index    = 3'd0;
    case (s)
      ST_TEXT:  c.index = 3'd0;
      ST_OPEN:  c.index = 3'd1;
      ST_TAG:   c.index = 3'd2;
      ST_SPACE: c.index = 3'd3;
      ST_NAME:  c.index = 3'd4;
      ST_EQ:    c.index = 3'd5;
      ST_VAL:   c.index = 3'd6;
      ST_CMT:   c.index = 3'd7;
      default:  c.coloured = 1'b0;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_DASH);
  endfunction

  function automatic logic is_tagc(logic [7:0] c);
    return is_ident(c) || (c == CH_SLASH);
  endfunction

endpackage

`default_nettype wire

FILE: design/mthl_lex.sv
// Lexer state registers and next-state logic for the markup tag lexer.
// Depends on mthl_pkg. Updates state on each fired beat.
`default_nettype none

module mthl_lex (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [7:0]          in_byte,
  output mthl_pkg::lex_res_t       res
);

  mthl_pkg::lex_state_t lex_state, lex_state_next;
  mthl_pkg::lex_state_t prev_state;
  logic                 quote_is_single, quote_is_single_next;
  logic [1:0]           dash_count, dash_count_next;
  logic                 error_flag;
  logic                 bad;
  mthl_pkg::lex_state_t ns;
  mthl_pkg::colour_t    col;

  always_comb begin
    ns                   = lex_state;
    bad                  = 1'b0;
    quote_is_single_next = quote_is_single;
    dash_count_next      = dash_count;
    case (lex_state)
      mthl_pkg::ST_TEXT: begin
        if (in_byte == mthl_pkg::CH_LT) ns = mthl_pkg::ST_OPEN;
      end
      mthl_pkg::ST_OPEN: begin
        if (mthl_pkg::is_tagc(in_byte)) ns = mthl_pkg::ST_TAG;
        else if (in_byte == mthl_pkg::CH_BANG) ns = mthl_pkg::ST_BANG;
        else bad = 1'b1;
      end
      mthl_pkg::ST_BANG: begin
        if (in_byte == mthl_pkg::CH_DASH) begin
          ns              = mthl_pkg::ST_CMT;
          dash_count_next = 2'd0;
        end else bad = 1'b1;
      end
      mthl_pkg::ST_CMT: begin
        if (in_byte == mthl_pkg::CH_DASH) begin
          if (dash_count != mthl_pkg::DASH_MAX) dash_count_next = dash_count + 2'd1;
        end else if (in_byte == mthl_pkg::CH_GT && dash_count >= 2'd2) begin
          ns = mthl_pkg::ST_TEXT;
        end else begin
          dash_count_next = 2'd0;
        end
      end
      mthl_pkg::ST_TAG: begin
        if (mthl_pkg::is_tagc(in_byte)) ns = mthl_pkg::ST_TAG;
        else if (in_byte == mthl_pkg::CH_GT) ns = mthl_pkg::ST_TEXT;
        else if (mthl_pkg::is_ws(in_byte)) ns = mthl_pkg::ST_SPACE;
        else bad = 1'b1;
      end
      mthl_pkg::ST_SPACE: begin
        if (mthl_pkg::is_ws(in_byte)) ns = mthl_pkg::ST_SPACE;
        else if (in_byte == mthl_pkg::CH_SLASH) ns = mthl_pkg::ST_SLASH;
        else if (in_byte == mthl_pkg::CH_GT) ns = mthl_pkg::ST_TEXT;
        else if (mthl_pkg::is_ident(in_byte)) ns = mthl_pkg::ST_NAME;
        else bad = 1'b1;
      end
      mthl_pkg::ST_SLASH: begin
        if (in_byte == mthl_pkg::CH_GT) ns = mthl_pkg::ST_TEXT;
        else bad = 1'b1;
      end
      mthl_pkg::ST_NAME: begin
        if (mthl_pkg::is_ident(in_byte)) ns = mthl_pkg::ST_NAME;
        else if (in_byte == mthl_pkg::CH_EQ) ns = mthl_pkg::ST_EQ;
        else if (in_byte == mthl_pkg::CH_GT) ns = mthl_pkg::ST_TEXT;
        else bad = 1'b1;
      end
      mthl_pkg::ST_EQ: begin
        if (in_byte == mthl_pkg::CH_DQ) begin
          ns                   = mthl_pkg::ST_VAL;
          quote_is_single_next = 1'b0;
        end else if (in_byte == mthl_pkg::CH_SQ) begin
          ns                   = mthl_pkg::ST_VAL;
          quote_is_single_next = 1'b1;
        end else bad = 1'b1;
      end
      mthl_pkg::ST_VAL: begin
        if (in_byte == (quote_is_single ? mthl_pkg::CH_SQ : mthl_pkg::CH_DQ))
          ns = mthl_pkg::ST_AFTER;
      end
      mthl_pkg::ST_AFTER: begin
        if (mthl_pkg::is_ws(in_byte)) ns = mthl_pkg::ST_SPACE;
        else if (in_byte == mthl_pkg::CH_GT) ns = mthl_pkg::ST_TEXT;
        else if (in_byte == mthl_pkg::CH_SLASH) ns = mthl_pkg::ST_SLASH;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    // Ignore a bad byte: hold state, counters and quote kind.
    lex_state_next = bad ? lex_state : ns;
    if (bad) begin
      quote_is_single_next = quote_is_single;
      dash_count_next      = dash_count;
    end
  end

  assign col = mthl_pkg::state_colour(lex_state_next);

  always_comb begin
    res.colour_change = col.coloured && (lex_state_next != prev_state);
    res.colour_index  = res.colour_change ? col.index : 3'd0;
    res.lex_error     = error_flag | bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state       <= mthl_pkg::ST_TEXT;
      prev_state      <= mthl_pkg::ST_NONE;
      quote_is_single <= 1'b0;
      dash_count      <= 2'd0;
      error_flag      <= 1'b0;
    end else if (fire) begin
      lex_state       <= lex_state_next;
      prev_state      <= lex_state_next;
      quote_is_single <= quote_is_single_next;
      dash_count      <= dash_count_next;
      error_flag      <= error_flag | bad;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_flag |=> error_flag)
    else $error("lex error flag cleared without reset");

  a_prev_tracks: assert property (@(posedge clk) disable iff (rst)
    fire |=> prev_state == lex_state)
    else $error("prev_state out of step with lex_state");

  a_bad_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && bad) |=> (lex_state == $past(lex_state)) && error_flag)
    else $error("bad byte moved the lexer");

  a_change_differs: assert property (@(posedge clk) disable iff (rst)
    res.colour_change |-> lex_state_next != prev_state)
    else $error("colour change without a state change");

endmodule

`default_nettype wire

FILE: design/markup_tag_lexer_highlighter_core.sv
// Top level of the markup tag lexer: input beat register, lexer, result register.
// Depends on mthl_pkg and mthl_lex.
//
//   channel | signals                                              | dir
//   input   | in_valid, in_stall, in_byte                          | in
//   output  | out_valid, out_stall, out_byte, colour_change,       | out
//           | colour_index, lex_error                              |
//
// One byte per cycle sustained while out_stall is low; a beat passes the input register, then the result register.
// The lexer state loop (state register through next-state logic) sets that rate.
// Reset (rst, synchronous) empties both registers and returns the lexer to text.
// out_stall holds the result register; the input register keeps taking a beat
// while it is empty, so a full pipe stalls the input only when both stages hold.
`default_nettype none

module markup_tag_lexer_highlighter_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_byte,
  output      logic       colour_change,
  output      logic [2:0] colour_index,
  output      logic       lex_error
);

  logic               hold_valid;
  logic [7:0]         hold_byte;
  logic               advance;
  mthl_pkg::lex_res_t res;

  // Advance a held beat into the result register when that register frees up.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  mthl_lex u_lex (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .in_byte (hold_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= hold_byte;
      colour_change <= res.colour_change;
      colour_index  <= res.colour_index;
      lex_error     <= res.lex_error;
    end
  end

endmodule

`default_nettype wire
